>>> rtl/core/bcs_pkg.sv
// Shared types and constants of the sampled Bezier closest-point search.
package bcs_pkg;

   // Largest interval count that the search accepts; larger settings are clamped.
   localparam logic [10:0] MAX_SLICES = 11'd1024;
   localparam logic [10:0] RESET_INTERVALS = 11'd64;

   // One step of the per-sample multiply schedule.
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_UU   = 5'd0;
   localparam logic [STEP_W-1:0] STEP_TT   = 5'd1;
   localparam logic [STEP_W-1:0] STEP_W0   = 5'd2;
   localparam logic [STEP_W-1:0] STEP_W1   = 5'd3;
   localparam logic [STEP_W-1:0] STEP_W2   = 5'd4;
   localparam logic [STEP_W-1:0] STEP_W3   = 5'd5;
   localparam logic [STEP_W-1:0] STEP_BX   = 5'd6;
   localparam logic [STEP_W-1:0] STEP_BY   = 5'd14;
   localparam logic [STEP_W-1:0] STEP_DX   = 5'd22;
   localparam logic [STEP_W-1:0] STEP_DY   = 5'd23;
   localparam logic [STEP_W-1:0] STEP_LAST = 5'd24;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic signed [31:0] ctrl0_x;
      logic signed [31:0] ctrl0_y;
      logic signed [31:0] ctrl1_x;
      logic signed [31:0] ctrl1_y;
      logic signed [31:0] ctrl2_x;
      logic signed [31:0] ctrl2_y;
      logic signed [31:0] ctrl3_x;
      logic signed [31:0] ctrl3_y;
      logic signed [31:0] query_x;
      logic signed [31:0] query_y;
   } req_type;

   typedef struct packed {
      logic [10:0] best_index;
      logic [16:0] best_param;
      logic [63:0] best_dist_sq;
   } rsp_type;

   // Status of the parameter step divider.
   typedef struct packed {
      logic        done;
      logic [16:0] quot;
      logic [10:0] rem;
   } div_result_type;

endpackage

>>> rtl/core/bcs_div.sv
// Restoring divider that splits 65536 by the interval count, one bit per cycle.
module bcs_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [10:0]             divisor,
   output bcs_pkg::div_result_type result
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [10:0] rem_ff;
   logic [16:0] quot_ff;
   logic [10:0] dvs_ff;
   logic        num_bit;
   logic [11:0] rem_sh;
   logic        fits;

   // The dividend 65536 has only its top bit set, which enters first.
   assign num_bit = (cnt_ff == 5'd0);
   assign rem_sh  = {rem_ff, num_bit};
   assign fits    = (rem_sh >= {1'b0, dvs_ff});

   // Control of the iteration.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Partial remainder and quotient bits.
   always_ff @(posedge clock) begin
      if (start) begin
         dvs_ff  <= divisor;
         rem_ff  <= 11'd0;
         quot_ff <= 17'd0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? 11'(rem_sh - {1'b0, dvs_ff}) : rem_sh[10:0];
         quot_ff <= {quot_ff[15:0], fits};
      end
   end

   assign result.done = done_ff;
   assign result.quot = quot_ff;
   assign result.rem  = rem_ff;

endmodule

>>> rtl/core/bcs_mul.sv
// Shared signed 35 by 35 multiplier with a registered product.
module bcs_mul (
   input  logic                clock,
   input  logic                enable,
   input  logic signed [34:0]  op_a,
   input  logic signed [34:0]  op_b,
   output logic signed [69:0]  prod
);

   logic signed [69:0] prod_ff;

   // The product is held while the sequencer stalls.
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= op_a * op_b;
      end
   end

   assign prod = prod_ff;

endmodule

>>> rtl/core/bezier_closest_sample_search.sv
// Top level: sequencer and datapath of the sampled Bezier closest-point search.
//
// Each request carries four control points and a query point in signed Q16.16 and
// yields one response: the curve sample nearest the query, its index, parameter
// and squared distance (Q32, saturated). The curve is sampled at S+1 points, with S
// the csr interval count clamped to 1..1024. A request first runs the bit-serial
// division that sets the parameter step, then a schedule of steps for each sample;
// each step but the last issues one multiply to the single shared 35x35 multiplier.
// A new request is accepted only when the previous one has finished its search;
// a finished response waits in the output register until it is taken.
module bezier_closest_sample_search (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bcs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bcs_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [10:0]      csr_wdata
);

   bcs_pkg::state_type state_ff, state_in;
   logic [bcs_pkg::STEP_W-1:0] step_ff, step_in, wb_step;
   logic [10:0]  csr_ff;
   logic [10:0]  s_eff, s_eff_ff;
   logic [10:0]  i_ff;
   logic [16:0]  t_ff, q0_ff;
   logic [10:0]  r_ff, r0_ff;
   logic [16:0]  u_val;
   logic [11:0]  r_sum;
   logic         r_wrap;
   logic signed [31:0] px_ff [4];
   logic signed [31:0] py_ff [4];
   logic signed [31:0] qx_ff, qy_ff;
   logic [32:0]  uu_ff, tt_ff;
   logic [48:0]  w_ff [4];
   logic signed [81:0] acc_x_ff, acc_y_ff;
   logic [63:0]  sqx_ff;
   logic [63:0]  best_d_ff;
   logic [10:0]  best_i_ff;
   logic [16:0]  best_t_ff;
   logic         rsp_valid_ff;
   bcs_pkg::rsp_type rsp_data_ff;
   logic         accept, last_sample, hold, advance, finish;
   logic         div_start;
   bcs_pkg::div_result_type div_res;
   logic signed [34:0] op_a, op_b;
   logic signed [69:0] prod;
   logic [48:0]  prod_w, prod_w3;
   logic signed [81:0] prod_ext, prod_add;
   logic [4:0]   bj, wj;
   logic signed [31:0] x_val, y_val;
   logic signed [32:0] dx, dy;
   logic [64:0]  d_sum;
   logic [63:0]  d_val;
   logic         better;

   // Configuration register and its clamped value.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= bcs_pkg::RESET_INTERVALS;
      end else if (csr_we) begin
         csr_ff <= csr_wdata;
      end
   end

   always_comb begin
      priority if (csr_ff == 11'd0) begin
         s_eff = 11'd1;
      end else if (csr_ff > bcs_pkg::MAX_SLICES) begin
         s_eff = bcs_pkg::MAX_SLICES;
      end else begin
         s_eff = csr_ff;
      end
   end

   assign accept      = req_valid && req_ready;
   assign last_sample = (i_ff == s_eff_ff);
   assign hold        = (state_ff == bcs_pkg::ST_RUN) && (step_ff == bcs_pkg::STEP_LAST)
                        && last_sample && rsp_valid_ff && !rsp_ready;
   assign advance     = (state_ff == bcs_pkg::ST_RUN) && !hold;
   assign finish      = (state_ff == bcs_pkg::ST_RUN) && (step_ff == bcs_pkg::STEP_LAST)
                        && last_sample && !hold;
   assign div_start   = accept;
   assign req_ready   = (state_ff == bcs_pkg::ST_IDLE);

   // Sequencer: state and step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcs_pkg::ST_IDLE;
         step_ff  <= bcs_pkg::STEP_UU;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         bcs_pkg::ST_IDLE: begin
            step_in = bcs_pkg::STEP_UU;
            if (accept) begin
               state_in = bcs_pkg::ST_DIV;
            end
         end
         bcs_pkg::ST_DIV: begin
            if (div_res.done) begin
               state_in = bcs_pkg::ST_RUN;
            end
         end
         bcs_pkg::ST_RUN: begin
            if (advance) begin
               if (step_ff == bcs_pkg::STEP_LAST) begin
                  step_in = bcs_pkg::STEP_UU;
                  if (last_sample) begin
                     state_in = bcs_pkg::ST_IDLE;
                  end
               end else begin
                  step_in = step_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = bcs_pkg::ST_IDLE;
         end
      endcase
   end

   // Parameter step divider.
   bcs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (s_eff),
      .result  (div_res)
   );

   // Latch the request.
   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff[0] <= req_data.ctrl0_x;
         py_ff[0] <= req_data.ctrl0_y;
         px_ff[1] <= req_data.ctrl1_x;
         py_ff[1] <= req_data.ctrl1_y;
         px_ff[2] <= req_data.ctrl2_x;
         py_ff[2] <= req_data.ctrl2_y;
         px_ff[3] <= req_data.ctrl3_x;
         py_ff[3] <= req_data.ctrl3_y;
         qx_ff    <= req_data.query_x;
         qy_ff    <= req_data.query_y;
         s_eff_ff <= s_eff;
      end
   end

   // Sample parameter: t advances by 65536/S with the remainder carried exactly.
   assign u_val  = 17'h10000 - t_ff;
   assign r_sum  = {1'b0, r_ff} + {1'b0, r0_ff};
   assign r_wrap = (r_sum >= {1'b0, s_eff_ff});

   always_ff @(posedge clock) begin
      if (state_ff == bcs_pkg::ST_DIV && div_res.done) begin
         q0_ff <= div_res.quot;
         r0_ff <= div_res.rem;
         t_ff  <= 17'd0;
         r_ff  <= 11'd0;
         i_ff  <= 11'd0;
      end else if (advance && step_ff == bcs_pkg::STEP_LAST && !last_sample) begin
         i_ff <= i_ff + 11'd1;
         if (r_wrap) begin
            r_ff <= 11'(r_sum - {1'b0, s_eff_ff});
            t_ff <= t_ff + q0_ff + 17'd1;
         end else begin
            r_ff <= r_sum[10:0];
            t_ff <= t_ff + q0_ff;
         end
      end
   end

   // Blended coordinates and their offsets from the query point.
   assign x_val = acc_x_ff[79:48];
   assign y_val = acc_y_ff[79:48];
   assign dx    = 33'(x_val) - 33'(qx_ff);
   assign dy    = 33'(y_val) - 33'(qy_ff);

   // Operand selection for the shared multiplier.
   assign bj = step_ff - bcs_pkg::STEP_BX;
   always_comb begin
      op_a = 35'sd0;
      op_b = 35'sd0;
      priority if (step_ff == bcs_pkg::STEP_UU) begin
         op_a = $signed({18'd0, u_val});
         op_b = $signed({18'd0, u_val});
      end else if (step_ff == bcs_pkg::STEP_TT) begin
         op_a = $signed({18'd0, t_ff});
         op_b = $signed({18'd0, t_ff});
      end else if (step_ff == bcs_pkg::STEP_W0) begin
         op_a = $signed({2'd0, uu_ff});
         op_b = $signed({18'd0, u_val});
      end else if (step_ff == bcs_pkg::STEP_W1) begin
         op_a = $signed({2'd0, uu_ff});
         op_b = $signed({18'd0, t_ff});
      end else if (step_ff == bcs_pkg::STEP_W2) begin
         op_a = $signed({2'd0, tt_ff});
         op_b = $signed({18'd0, u_val});
      end else if (step_ff == bcs_pkg::STEP_W3) begin
         op_a = $signed({2'd0, tt_ff});
         op_b = $signed({18'd0, t_ff});
      end else if (step_ff < bcs_pkg::STEP_DX) begin
         // Low or high part of one weight times one control coordinate.
         op_a = bj[0] ? $signed({10'd0, w_ff[bj[2:1]][48:24]})
                      : $signed({11'd0, w_ff[bj[2:1]][23:0]});
         op_b = (step_ff < bcs_pkg::STEP_BY) ? 35'(px_ff[bj[2:1]])
                                             : 35'(py_ff[bj[2:1]]);
      end else if (step_ff == bcs_pkg::STEP_DX) begin
         op_a = 35'(dx);
         op_b = 35'(dx);
      end else if (step_ff == bcs_pkg::STEP_DY) begin
         op_a = 35'(dy);
         op_b = 35'(dy);
      end else begin
         // The last step of a sample issues no multiply.
         op_a = 35'sd0;
         op_b = 35'sd0;
      end
   end

   bcs_mul u_mul (
      .clock  (clock),
      .enable (advance),
      .op_a   (op_a),
      .op_b   (op_b),
      .prod   (prod)
   );

   // Write back the product issued in the previous step.
   assign wb_step  = step_ff - 5'd1;
   assign wj       = wb_step - bcs_pkg::STEP_BX;
   assign prod_w   = prod[48:0];
   assign prod_w3  = prod_w + {prod_w[47:0], 1'b0};
   assign prod_ext = 82'(prod);
   assign prod_add = wj[0] ? (prod_ext <<< 24) : prod_ext;

   always_ff @(posedge clock) begin
      if (advance) begin
         if (step_ff == bcs_pkg::STEP_UU) begin
            acc_x_ff <= 82'sd0;
            acc_y_ff <= 82'sd0;
         end else begin
            priority if (wb_step == bcs_pkg::STEP_UU) begin
               uu_ff <= prod[32:0];
            end else if (wb_step == bcs_pkg::STEP_TT) begin
               tt_ff <= prod[32:0];
            end else if (wb_step == bcs_pkg::STEP_W0) begin
               w_ff[0] <= prod_w;
            end else if (wb_step == bcs_pkg::STEP_W1) begin
               w_ff[1] <= prod_w3;
            end else if (wb_step == bcs_pkg::STEP_W2) begin
               w_ff[2] <= prod_w3;
            end else if (wb_step == bcs_pkg::STEP_W3) begin
               w_ff[3] <= prod_w;
            end else if (wb_step < bcs_pkg::STEP_BY) begin
               acc_x_ff <= acc_x_ff + prod_add;
            end else if (wb_step < bcs_pkg::STEP_DX) begin
               acc_y_ff <= acc_y_ff + prod_add;
            end else if (wb_step == bcs_pkg::STEP_DX) begin
               sqx_ff <= prod[63:0];
            end else begin
               // The square of dy feeds the distance sum straight from the multiplier.
            end
         end
      end
   end

   // Distance of this sample, saturated, and the running best.
   assign d_sum  = {1'b0, sqx_ff} + {1'b0, prod[63:0]};
   assign d_val  = d_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : d_sum[63:0];
   assign better = (i_ff == 11'd0) || (d_val < best_d_ff);

   always_ff @(posedge clock) begin
      if (state_ff == bcs_pkg::ST_RUN && step_ff == bcs_pkg::STEP_LAST && better) begin
         best_d_ff <= d_val;
         best_i_ff <= i_ff;
         best_t_ff <= t_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff.best_index   <= better ? i_ff : best_i_ff;
         rsp_data_ff.best_param   <= better ? t_ff : best_t_ff;
         rsp_data_ff.best_dist_sq <= better ? d_val : best_d_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The parameter never passes one and the carried remainder stays below S.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == bcs_pkg::ST_RUN |-> (t_ff <= 17'h10000 && r_ff < s_eff_ff))
      else $error("sample parameter or remainder out of range");

   // The last sample lands exactly on the curve end.
   assert property (@(posedge clock) disable iff (reset)
      finish |-> t_ff == 17'h10000)
      else $error("last sample is not at the curve end");

   // A response is only finished while the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   // The divider reports only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == bcs_pkg::ST_DIV)
      else $error("divider result outside the divide phase");

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the sampled Bezier closest-point search.
`timescale 1ns / 100ps

module tb_top;

   localparam int CYCLE_LIMIT = 3000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   bcs_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   bcs_pkg::rsp_type rsp_data;
   logic    csr_we;
   logic [10:0] csr_wdata;

   // Mirror of the interval register, and the responses still owed.
   logic [10:0] interval_setting;
   bcs_pkg::rsp_type nearest_queue[$];
   int          error_count;
   int          request_count;
   int          response_count;
   int          cycle_count;
   bit          quiet_mode;
   int          stall_left;

   bezier_closest_sample_search u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Clock with a 10 ns period; the first rising edge comes at 5 ns.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Random idle length: mostly short, now and then long.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_mode || roll < 55) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 4);
      end else begin
         return $urandom_range(10, 120);
      end
   endfunction

   // Floor of the Bernstein-weighted sum of four coordinates, divided by 2^48.
   function automatic longint blend_coord(logic [63:0] w0, logic [63:0] w1,
                                          logic [63:0] w2, logic [63:0] w3,
                                          logic signed [31:0] p0, logic signed [31:0] p1,
                                          logic signed [31:0] p2, logic signed [31:0] p3);
      logic signed [95:0] acc;
      acc = $signed({32'd0, w0}) * 96'(p0);
      acc = acc + $signed({32'd0, w1}) * 96'(p1);
      acc = acc + $signed({32'd0, w2}) * 96'(p2);
      acc = acc + $signed({32'd0, w3}) * 96'(p3);
      return longint'(acc >>> 48);
   endfunction

   // Squared distance; each square wraps at 64 bits and only the sum saturates.
   function automatic logic [63:0] dist_squared(longint x, longint y, longint qx, longint qy);
      longint      dx;
      longint      dy;
      logic [63:0] ax;
      logic [63:0] ay;
      logic [64:0] total;
      dx = x - qx;
      dy = y - qy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      total = {1'b0, ax * ax} + {1'b0, ay * ay};
      return total[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total[63:0];
   endfunction

   // Expected response: search all samples, first sample wins ties.
   function automatic bcs_pkg::rsp_type nearest_sample(bcs_pkg::req_type r,
                                                       logic [10:0] setting);
      longint unsigned s;
      longint unsigned t;
      longint unsigned u;
      longint          cx;
      longint          cy;
      logic [63:0]     d;
      bcs_pkg::rsp_type best;
      s = setting;
      if (s == 0) s = 1;
      if (s > bcs_pkg::MAX_SLICES) s = bcs_pkg::MAX_SLICES;
      best = '0;
      for (longint unsigned i = 0; i <= s; i++) begin
         t = (i * 65536) / s;
         u = 65536 - t;
         cx = blend_coord(u * u * u, 3 * u * u * t, 3 * u * t * t, t * t * t,
                          r.ctrl0_x, r.ctrl1_x, r.ctrl2_x, r.ctrl3_x);
         cy = blend_coord(u * u * u, 3 * u * u * t, 3 * u * t * t, t * t * t,
                          r.ctrl0_y, r.ctrl1_y, r.ctrl2_y, r.ctrl3_y);
         d = dist_squared(cx, cy, longint'(r.query_x), longint'(r.query_y));
         if (i == 0 || d < best.best_dist_sq) begin
            best.best_index = 11'(i);
            best.best_param = 17'(t);
            best.best_dist_sq = d;
         end
      end
      return best;
   endfunction

   // Random coordinate: full range, small, extreme, or near a base value.
   function automatic logic signed [31:0] random_coord(logic signed [31:0] base);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2: return base + $signed(32'($urandom_range(0, 8191)) - 32'sd4096);
         default: return $signed(32'($urandom_range(0, 2097151)) - 32'sd1048576);
      endcase
   endfunction

   function automatic bcs_pkg::req_type random_request();
      bcs_pkg::req_type r;
      r.ctrl0_x = random_coord(32'sd0);
      r.ctrl0_y = random_coord(32'sd0);
      r.ctrl1_x = random_coord(r.ctrl0_x);
      r.ctrl1_y = random_coord(r.ctrl0_y);
      r.ctrl2_x = random_coord(r.ctrl1_x);
      r.ctrl2_y = random_coord(r.ctrl1_y);
      r.ctrl3_x = random_coord(r.ctrl2_x);
      r.ctrl3_y = random_coord(r.ctrl2_y);
      r.query_x = random_coord(r.ctrl3_x);
      r.query_y = random_coord(r.ctrl0_y);
      return r;
   endfunction

   function automatic bcs_pkg::req_type uniform_request(logic signed [31:0] c,
                                                        logic signed [31:0] q);
      bcs_pkg::req_type r;
      r = {c, c, c, c, c, c, c, c, q, q};
      return r;
   endfunction

   // Send one request; valid stays high into the next call when there is no gap.
   task automatic send_request(bcs_pkg::req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      nearest_queue = {nearest_queue, nearest_sample(r, interval_setting)};
      request_count++;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait for the block to drain, then write the interval register.
   task automatic write_intervals(logic [10:0] value);
      req_valid <= 1'b0;
      while (nearest_queue.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      interval_setting = value;
   endtask

   // Corners at the reset setting: extremes, ties, saturation, endpoints.
   task automatic test_reset_setting_corners();
      bcs_pkg::req_type r;
      send_request(uniform_request(32'sd0, 32'sd0));
      send_request(uniform_request(32'sh7FFF_FFFF, 32'sh8000_0000));
      send_request(uniform_request(32'sh8000_0000, 32'sh7FFF_FFFF));
      send_request(uniform_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_request(uniform_request(32'sh8000_0000, 32'sh8000_0000));
      send_request(uniform_request(32'shAAAA_AAAA, 32'sh5555_5555));
      send_request(uniform_request(32'sh5555_5555, 32'shAAAA_AAAA));
      send_request(uniform_request(32'sd65536, 32'sh7FFF_FFFF));
      r = {32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
           32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
           32'sh8000_0000, 32'sh8000_0000};
      send_request(r);
      r.query_x = 32'sh7FFF_FFFF;
      r.query_y = 32'sh7FFF_FFFF;
      send_request(r);
      r.query_x = 32'sd0;
      r.query_y = 32'sd0;
      send_request(r);
      // A straight line from the origin; query at each end, near the middle and beyond the start.
      r = {32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd131072, 32'sd0,
           32'sd196608, 32'sd0, 32'sd0, 32'sd0};
      send_request(r);
      r.query_x = 32'sd196608;
      send_request(r);
      r.query_x = 32'sd98304;
      r.query_y = 32'sd5000;
      send_request(r);
      r.query_x = -32'sd500000;
      send_request(r);
      repeat (8) send_request(random_request());
   endtask

   // One phase of random requests at a given interval setting.
   task automatic test_random_at(logic [10:0] value, int count, bit quiet);
      write_intervals(value);
      quiet_mode = quiet;
      for (int n = 0; n < count; n++) begin
         send_request(random_request());
      end
      quiet_mode = 1'b0;
   endtask

   // Settings of zero and above the maximum are clamped; the maximum itself is also run.
   task automatic test_interval_clamping();
      test_random_at(11'd0, 10, 1'b0);
      test_random_at(11'd1024, 2, 1'b0);
      test_random_at(11'd2047, 2, 1'b0);
      test_random_at(11'd1500, 1, 1'b0);
   endtask

   // Bulk of the run at small settings, where each search is short.
   task automatic test_random_sweep();
      test_random_at(11'd1, 300, 1'b0);
      test_random_at(11'd2, 250, 1'b0);
      test_random_at(11'd3, 50, 1'b1);
      test_random_at(11'd3, 150, 1'b0);
      test_random_at(11'd5, 200, 1'b0);
      test_random_at(11'd8, 150, 1'b0);
      test_random_at(11'd16, 100, 1'b0);
      test_random_at(11'd64, 40, 1'b0);
   endtask

   // Result side: random stalls, with stretches of none while quiet.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
         stall_left <= idle_length();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each response with the oldest expectation.
   always @(posedge clock) begin
      bcs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         response_count++;
         if (nearest_queue.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            want = nearest_queue.pop_front();
            if (rsp_data.best_index !== want.best_index) begin
               $display("%0t: best_index expected %0d actual %0d", $time,
                        want.best_index, rsp_data.best_index);
               error_count++;
            end
            if (rsp_data.best_param !== want.best_param) begin
               $display("%0t: best_param expected %0d actual %0d", $time,
                        want.best_param, rsp_data.best_param);
               error_count++;
            end
            if (rsp_data.best_dist_sq !== want.best_dist_sq) begin
               $display("%0t: best_dist_sq expected %h actual %h", $time,
                        want.best_dist_sq, rsp_data.best_dist_sq);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      interval_setting = bcs_pkg::RESET_INTERVALS;
      error_count = 0;
      request_count = 0;
      response_count = 0;
      cycle_count = 0;
      quiet_mode = 1'b0;
      stall_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_setting_corners();
      test_interval_clamping();
      test_random_sweep();

      req_valid <= 1'b0;
      while (nearest_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Covered %0d requests and %0d responses over interval settings 0 to 2047.",
               request_count, response_count);
      if (error_count == 0 && nearest_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
